[rtl/core/chti_pkg.sv]
// ----------------------------------------------------------------------------
// chti_pkg - shared types, constants and microcode for the triangle intersector
// Scratch-memory map, micro-op format, fixed-point helpers and the program
// that the back end steps through for each triangle.
// ----------------------------------------------------------------------------
package chti_pkg;

  // Q16.16
  localparam int          FX_W       = 32;
  localparam logic [31:0] FX_ONE     = 32'h0001_0000;
  localparam int          PROD_W     = 64;
  localparam int          ACC_W      = 52;   // six 48-bit terms summed exactly
  localparam int          DIST_W     = 31;
  localparam int          IDX_W      = 16;
  localparam int          NCOORD     = 9;
  localparam int          LC_W       = 4;
  localparam int          DIV_STEPS  = 48;
  localparam int          DIV_CNT_W  = 6;
  localparam int          QDEPTH     = 2;
  localparam int          MAX_TRIANGLES_DEF = 65536;
  localparam logic [30:0] MAX_DIST_RST = 31'h7FFF_FFFF;

  // configuration register index
  localparam logic        CFG_IDX_MAX_DIST = 1'b0;

  // input / output channel widths
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 144;

  // scratch memory
  localparam int AW     = 6;
  localparam int MDEPTH = 64;
  localparam logic [AW-1:0] A_A0  = 6'd0;
  localparam logic [AW-1:0] A_B0  = 6'd3;
  localparam logic [AW-1:0] A_C0  = 6'd6;
  localparam logic [AW-1:0] A_O0  = 6'd9;
  localparam logic [AW-1:0] A_D0  = 6'd12;
  localparam logic [AW-1:0] A_RAY_END = 6'd14;
  localparam logic [AW-1:0] A_CB0 = 6'd16;
  localparam logic [AW-1:0] A_AB0 = 6'd19;
  localparam logic [AW-1:0] A_N0  = 6'd22;
  localparam logic [AW-1:0] A_NDD = 6'd25;
  localparam logic [AW-1:0] A_NUM = 6'd26;
  localparam logic [AW-1:0] A_T   = 6'd27;
  localparam logic [AW-1:0] A_PT0 = 6'd28;
  localparam logic [AW-1:0] A_V00 = 6'd32;
  localparam logic [AW-1:0] A_V10 = 6'd35;
  localparam logic [AW-1:0] A_V20 = 6'd38;
  localparam logic [AW-1:0] A_D00 = 6'd41;
  localparam logic [AW-1:0] A_D01 = 6'd42;
  localparam logic [AW-1:0] A_D11 = 6'd43;
  localparam logic [AW-1:0] A_D20 = 6'd44;
  localparam logic [AW-1:0] A_D21 = 6'd45;
  localparam logic [AW-1:0] A_DEN = 6'd46;
  localparam logic [AW-1:0] A_VN  = 6'd47;
  localparam logic [AW-1:0] A_V   = 6'd48;
  localparam logic [AW-1:0] A_WN  = 6'd49;
  localparam logic [AW-1:0] A_W   = 6'd50;
  localparam logic [AW-1:0] A_U   = 6'd51;
  localparam logic [AW-1:0] A_ONE = 6'd63;  // reads as 1.0, never written

  localparam int PROG_LEN = 78;
  localparam int PC_W     = 7;
  localparam logic [PC_W-1:0] PC_LAST = 7'(PROG_LEN - 1);

  typedef enum logic {OP_MAC, OP_DIV} op_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_NZ, CHK_POS, CHK_UNIT} chk_t;

  typedef struct packed {
    op_t           op;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic          neg;
    logic          first;
    logic          last;
    logic [AW-1:0] dst;
    chk_t          chk;
  } uop_t;

  typedef struct packed {
    logic                     is_tri;
    logic                     emit;
    logic [NCOORD-1:0][31:0]  p;
  } fe_item_t;

  typedef struct packed {
    logic     valid;
    fe_item_t item;
  } fe_head_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_LOAD, BK_RD, BK_MUL, BK_ACC, BK_DVS, BK_DVW, BK_DECIDE, BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_t;

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic [31:0] r;
    if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1) r = x[31:0];
    else if (x[ACC_W-1]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

  function automatic logic chk_miss(input chk_t c, input logic [31:0] v);
    logic m;
    unique case (c)
      CHK_NZ:   m = (v == '0);
      CHK_POS:  m = v[31] || (v == '0);
      CHK_UNIT: m = v[31] || (v > FX_ONE);
      default:  m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic uop_t mf(input logic [AW-1:0] a, input logic [AW-1:0] b);
    uop_t u;
    u = '{op: OP_MAC, a: a, b: b, neg: 1'b0, first: 1'b1, last: 1'b0,
          dst: A_T, chk: CHK_NONE};
    return u;
  endfunction

  function automatic uop_t mm(input logic [AW-1:0] a, input logic [AW-1:0] b,
                              input logic neg);
    uop_t u;
    u = '{op: OP_MAC, a: a, b: b, neg: neg, first: 1'b0, last: 1'b0,
          dst: A_T, chk: CHK_NONE};
    return u;
  endfunction

  function automatic uop_t ml(input logic [AW-1:0] a, input logic [AW-1:0] b,
                              input logic neg, input logic [AW-1:0] dst,
                              input chk_t chk);
    uop_t u;
    u = '{op: OP_MAC, a: a, b: b, neg: neg, first: 1'b0, last: 1'b1,
          dst: dst, chk: chk};
    return u;
  endfunction

  function automatic uop_t dv(input logic [AW-1:0] num, input logic [AW-1:0] den,
                              input logic [AW-1:0] dst, input chk_t chk);
    uop_t u;
    u = '{op: OP_DIV, a: num, b: den, neg: 1'b0, first: 1'b1, last: 1'b1,
          dst: dst, chk: chk};
    return u;
  endfunction

  // per-triangle program; every sum is exact and saturated once on write
  function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // cb = c - b, ab = a - b
      7'd0:  u = mf(A_C0, A_ONE);
      7'd1:  u = ml(A_B0, A_ONE, 1'b1, A_CB0, CHK_NONE);
      7'd2:  u = mf(A_C0 + 6'd1, A_ONE);
      7'd3:  u = ml(A_B0 + 6'd1, A_ONE, 1'b1, A_CB0 + 6'd1, CHK_NONE);
      7'd4:  u = mf(A_C0 + 6'd2, A_ONE);
      7'd5:  u = ml(A_B0 + 6'd2, A_ONE, 1'b1, A_CB0 + 6'd2, CHK_NONE);
      7'd6:  u = mf(A_A0, A_ONE);
      7'd7:  u = ml(A_B0, A_ONE, 1'b1, A_AB0, CHK_NONE);
      7'd8:  u = mf(A_A0 + 6'd1, A_ONE);
      7'd9:  u = ml(A_B0 + 6'd1, A_ONE, 1'b1, A_AB0 + 6'd1, CHK_NONE);
      7'd10: u = mf(A_A0 + 6'd2, A_ONE);
      7'd11: u = ml(A_B0 + 6'd2, A_ONE, 1'b1, A_AB0 + 6'd2, CHK_NONE);
      // n = cross(cb, ab)
      7'd12: u = mf(A_CB0 + 6'd1, A_AB0 + 6'd2);
      7'd13: u = ml(A_CB0 + 6'd2, A_AB0 + 6'd1, 1'b1, A_N0, CHK_NONE);
      7'd14: u = mf(A_CB0 + 6'd2, A_AB0);
      7'd15: u = ml(A_CB0, A_AB0 + 6'd2, 1'b1, A_N0 + 6'd1, CHK_NONE);
      7'd16: u = mf(A_CB0, A_AB0 + 6'd1);
      7'd17: u = ml(A_CB0 + 6'd1, A_AB0, 1'b1, A_N0 + 6'd2, CHK_NONE);
      // n.dir, parallel ray misses
      7'd18: u = mf(A_N0, A_D0);
      7'd19: u = mm(A_N0 + 6'd1, A_D0 + 6'd1, 1'b0);
      7'd20: u = ml(A_N0 + 6'd2, A_D0 + 6'd2, 1'b0, A_NDD, CHK_NZ);
      // n.a - n.origin
      7'd21: u = mf(A_N0, A_A0);
      7'd22: u = mm(A_N0, A_O0, 1'b1);
      7'd23: u = mm(A_N0 + 6'd1, A_A0 + 6'd1, 1'b0);
      7'd24: u = mm(A_N0 + 6'd1, A_O0 + 6'd1, 1'b1);
      7'd25: u = mm(A_N0 + 6'd2, A_A0 + 6'd2, 1'b0);
      7'd26: u = ml(A_N0 + 6'd2, A_O0 + 6'd2, 1'b1, A_NUM, CHK_NONE);
      7'd27: u = dv(A_NUM, A_NDD, A_T, CHK_POS);
      // hit point
      7'd28: u = mf(A_O0, A_ONE);
      7'd29: u = ml(A_D0, A_T, 1'b0, A_PT0, CHK_NONE);
      7'd30: u = mf(A_O0 + 6'd1, A_ONE);
      7'd31: u = ml(A_D0 + 6'd1, A_T, 1'b0, A_PT0 + 6'd1, CHK_NONE);
      7'd32: u = mf(A_O0 + 6'd2, A_ONE);
      7'd33: u = ml(A_D0 + 6'd2, A_T, 1'b0, A_PT0 + 6'd2, CHK_NONE);
      // v0 = b - a, v1 = c - a, v2 = pt - a
      7'd34: u = mf(A_B0, A_ONE);
      7'd35: u = ml(A_A0, A_ONE, 1'b1, A_V00, CHK_NONE);
      7'd36: u = mf(A_B0 + 6'd1, A_ONE);
      7'd37: u = ml(A_A0 + 6'd1, A_ONE, 1'b1, A_V00 + 6'd1, CHK_NONE);
      7'd38: u = mf(A_B0 + 6'd2, A_ONE);
      7'd39: u = ml(A_A0 + 6'd2, A_ONE, 1'b1, A_V00 + 6'd2, CHK_NONE);
      7'd40: u = mf(A_C0, A_ONE);
      7'd41: u = ml(A_A0, A_ONE, 1'b1, A_V10, CHK_NONE);
      7'd42: u = mf(A_C0 + 6'd1, A_ONE);
      7'd43: u = ml(A_A0 + 6'd1, A_ONE, 1'b1, A_V10 + 6'd1, CHK_NONE);
      7'd44: u = mf(A_C0 + 6'd2, A_ONE);
      7'd45: u = ml(A_A0 + 6'd2, A_ONE, 1'b1, A_V10 + 6'd2, CHK_NONE);
      7'd46: u = mf(A_PT0, A_ONE);
      7'd47: u = ml(A_A0, A_ONE, 1'b1, A_V20, CHK_NONE);
      7'd48: u = mf(A_PT0 + 6'd1, A_ONE);
      7'd49: u = ml(A_A0 + 6'd1, A_ONE, 1'b1, A_V20 + 6'd1, CHK_NONE);
      7'd50: u = mf(A_PT0 + 6'd2, A_ONE);
      7'd51: u = ml(A_A0 + 6'd2, A_ONE, 1'b1, A_V20 + 6'd2, CHK_NONE);
      // dot products
      7'd52: u = mf(A_V00, A_V00);
      7'd53: u = mm(A_V00 + 6'd1, A_V00 + 6'd1, 1'b0);
      7'd54: u = ml(A_V00 + 6'd2, A_V00 + 6'd2, 1'b0, A_D00, CHK_NONE);
      7'd55: u = mf(A_V00, A_V10);
      7'd56: u = mm(A_V00 + 6'd1, A_V10 + 6'd1, 1'b0);
      7'd57: u = ml(A_V00 + 6'd2, A_V10 + 6'd2, 1'b0, A_D01, CHK_NONE);
      7'd58: u = mf(A_V10, A_V10);
      7'd59: u = mm(A_V10 + 6'd1, A_V10 + 6'd1, 1'b0);
      7'd60: u = ml(A_V10 + 6'd2, A_V10 + 6'd2, 1'b0, A_D11, CHK_NONE);
      7'd61: u = mf(A_V20, A_V00);
      7'd62: u = mm(A_V20 + 6'd1, A_V00 + 6'd1, 1'b0);
      7'd63: u = ml(A_V20 + 6'd2, A_V00 + 6'd2, 1'b0, A_D20, CHK_NONE);
      7'd64: u = mf(A_V20, A_V10);
      7'd65: u = mm(A_V20 + 6'd1, A_V10 + 6'd1, 1'b0);
      7'd66: u = ml(A_V20 + 6'd2, A_V10 + 6'd2, 1'b0, A_D21, CHK_NONE);
      // Cramer's rule
      7'd67: u = mf(A_D00, A_D11);
      7'd68: u = ml(A_D01, A_D01, 1'b1, A_DEN, CHK_NZ);
      7'd69: u = mf(A_D20, A_D11);
      7'd70: u = ml(A_D21, A_D01, 1'b1, A_VN, CHK_NONE);
      7'd71: u = dv(A_VN, A_DEN, A_V, CHK_UNIT);
      7'd72: u = mf(A_D00, A_D21);
      7'd73: u = ml(A_D01, A_D20, 1'b1, A_WN, CHK_NONE);
      7'd74: u = dv(A_WN, A_DEN, A_W, CHK_UNIT);
      7'd75: u = mf(A_ONE, A_ONE);
      7'd76: u = mm(A_W, A_ONE, 1'b1);
      7'd77: u = ml(A_V, A_ONE, 1'b1, A_U, CHK_UNIT);
      default: u = mf(A_ONE, A_ONE);
    endcase
    return u;
  endfunction

endpackage

[rtl/core/chti_front.sv]
// ----------------------------------------------------------------------------
// chti_front - request intake and classification
// Takes stream requests, tags them as ray load or triangle (and whether a
// result follows), and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module chti_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [chti_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output chti_pkg::fe_head_t              head,
  input  logic                            pop
);

  localparam int PTR_W = $clog2(chti_pkg::QDEPTH);
  localparam int CNT_W = $clog2(chti_pkg::QDEPTH + 1);

  chti_pkg::fe_item_t q_r [chti_pkg::QDEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               push;
  chti_pkg::fe_item_t item;

  assign in_tready = (cnt_r != CNT_W'(chti_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;

  always_comb begin
    item.is_tri = in_tuser;
    item.emit   = in_tuser && in_tlast;  // last mark on a ray load is dropped
    item.p      = in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTR_W'(chti_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PTR_W'(chti_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= item;
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

endmodule

[rtl/core/chti_div.sv]
// ----------------------------------------------------------------------------
// chti_div - Q16.16 divider
// Restoring division, one quotient bit a cycle: (num * 2^16) / den,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module chti_div (
  input  logic                clk,
  input  logic                rst_n,
  input  chti_pkg::div_req_t  req,
  output chti_pkg::div_rsp_t  rsp
);

  chti_pkg::dv_state_t                 state_r, state_nxt;
  logic [chti_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic                                neg_r;
  logic [31:0]                         den_r;
  logic [47:0]                         dvd_r;
  logic [31:0]                         rem_r;
  logic [47:0]                         quo_r;
  logic [32:0]                         trial;
  logic                                ge;
  logic [32:0]                         num_ext, den_ext, num_mag, den_mag;

  assign num_ext = {req.num[31], req.num};
  assign den_ext = {req.den[31], req.den};
  assign num_mag = num_ext[32] ? -num_ext : num_ext;
  assign den_mag = den_ext[32] ? -den_ext : den_ext;

  assign trial = {rem_r, dvd_r[47]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chti_pkg::DV_IDLE: if (req.start) state_nxt = chti_pkg::DV_RUN;
      chti_pkg::DV_RUN:  if (cnt_r == '0) state_nxt = chti_pkg::DV_DONE;
      chti_pkg::DV_DONE: state_nxt = chti_pkg::DV_IDLE;
      default:           state_nxt = chti_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == chti_pkg::DV_DONE);
    if (!neg_r) rsp.quo = (quo_r > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r[31:0];
    else        rsp.quo = (quo_r > 48'h0000_8000_0000) ? 32'h8000_0000 : -quo_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= chti_pkg::DV_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == chti_pkg::DV_IDLE && req.start) begin
      neg_r <= req.num[31] ^ req.den[31];
      den_r <= den_mag[31:0];
      dvd_r <= {num_mag[31:0], 16'h0000};
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= chti_pkg::DIV_CNT_W'(chti_pkg::DIV_STEPS - 1);
    end else if (state_r == chti_pkg::DV_RUN) begin
      rem_r <= ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quo_r <= {quo_r[46:0], ge};
      dvd_r <= {dvd_r[46:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[rtl/core/chti_back.sv]
// ----------------------------------------------------------------------------
// chti_back - microcoded intersection engine and nearest-hit tracker
// Loads a request into scratch memory, steps the per-triangle program on a
// shared multiply-accumulate unit and the divider, keeps the best hit.
// ----------------------------------------------------------------------------
module chti_back #(
  parameter int MAX_TRIANGLES = chti_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  chti_pkg::fe_head_t               head,
  output logic                             pop,
  input  logic [chti_pkg::DIST_W-1:0]      max_distance,
  output chti_pkg::div_req_t               dreq,
  input  chti_pkg::div_rsp_t               drsp,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [chti_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tuser
);

  localparam int CNT_W = $clog2(MAX_TRIANGLES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIANGLES - 1);

  chti_pkg::bk_state_t state_r, state_nxt;
  chti_pkg::uop_t      uop;

  logic [31:0]                   mem [chti_pkg::MDEPTH];
  logic [31:0]                   rda_r, rdb_r;
  logic                          a_one_r, b_one_r, a_zero_r, b_zero_r;
  logic signed [31:0]            opa, opb;
  logic signed [63:0]            prod_r;
  logic signed [chti_pkg::ACC_W-1:0] acc_r, acc_nxt, acc_base, term;

  logic [chti_pkg::PC_W-1:0]     pc_r;
  logic [chti_pkg::LC_W-1:0]     lc_r;
  logic                          load_last;
  logic                          ray_ok_r;
  logic                          miss_r;

  logic [31:0]                   cand_t_r;
  logic [31:0]                   cand_pt_r [3];
  logic [chti_pkg::DIST_W-1:0]   best_dist_r;
  logic [CNT_W-1:0]              best_idx_r, count_r;
  logic [31:0]                   best_pt_r [3];
  logic                          any_hit_r;
  logic                          is_hit;

  logic                          out_valid_r, out_hit_r;
  logic [chti_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                          out_free;

  // control from the output decode
  logic                          mem_we;
  logic [chti_pkg::AW-1:0]       mem_waddr;
  logic [31:0]                   mem_wdata;
  chti_pkg::chk_t                wr_chk;
  logic                          miss_set, pc_inc, lc_inc, tri_start;
  logic                          ray_done, clr_search, upd_best, out_load;
  logic                          den_zero;

  function automatic logic ray_addr(input logic [chti_pkg::AW-1:0] a);
    return (a >= chti_pkg::A_O0) && (a <= chti_pkg::A_RAY_END);
  endfunction

  assign uop       = chti_pkg::prog_rom(pc_r);
  assign load_last = head.item.is_tri ? (lc_r == chti_pkg::LC_W'(chti_pkg::NCOORD - 1))
                                      : (lc_r == chti_pkg::LC_W'(5));
  assign out_free  = !out_valid_r || out_tready;

  // operands: 1.0 pseudo-address, ray unloaded since reset reads as zero
  always_comb begin
    opa = a_one_r ? chti_pkg::FX_ONE : (a_zero_r ? 32'h0 : rda_r);
    opb = b_one_r ? chti_pkg::FX_ONE : (b_zero_r ? 32'h0 : rdb_r);
  end
  assign den_zero = (opb == '0);

  always_comb begin
    acc_base = uop.first ? '0 : acc_r;
    term     = chti_pkg::ACC_W'($signed(prod_r[63:16]));   // floor(x*y / 2^16)
    acc_nxt  = uop.neg ? acc_base - term : acc_base + term;
  end

  assign is_hit = !miss_r && ($signed(cand_t_r) < $signed({1'b0, best_dist_r}));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chti_pkg::BK_IDLE: if (head.valid) state_nxt = chti_pkg::BK_LOAD;
      chti_pkg::BK_LOAD:
        if (load_last) state_nxt = head.item.is_tri ? chti_pkg::BK_RD : chti_pkg::BK_IDLE;
      chti_pkg::BK_RD:
        state_nxt = (uop.op == chti_pkg::OP_DIV) ? chti_pkg::BK_DVS : chti_pkg::BK_MUL;
      chti_pkg::BK_MUL: state_nxt = chti_pkg::BK_ACC;
      chti_pkg::BK_ACC:
        state_nxt = (pc_r == chti_pkg::PC_LAST) ? chti_pkg::BK_DECIDE : chti_pkg::BK_RD;
      chti_pkg::BK_DVS: state_nxt = den_zero ? chti_pkg::BK_RD : chti_pkg::BK_DVW;
      chti_pkg::BK_DVW: if (drsp.done) state_nxt = chti_pkg::BK_RD;
      chti_pkg::BK_DECIDE:
        state_nxt = head.item.emit ? chti_pkg::BK_EMIT : chti_pkg::BK_IDLE;
      chti_pkg::BK_EMIT: if (out_free) state_nxt = chti_pkg::BK_IDLE;
      default: state_nxt = chti_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = uop.dst;
    mem_wdata  = chti_pkg::sat32(acc_nxt);
    wr_chk     = uop.chk;
    miss_set   = 1'b0;
    pc_inc     = 1'b0;
    lc_inc     = 1'b0;
    tri_start  = 1'b0;
    ray_done   = 1'b0;
    clr_search = 1'b0;
    upd_best   = 1'b0;
    out_load   = 1'b0;
    pop        = 1'b0;
    dreq.start = 1'b0;
    dreq.num   = opa;
    dreq.den   = opb;
    unique case (state_r)
      chti_pkg::BK_LOAD: begin
        mem_we    = 1'b1;
        mem_waddr = head.item.is_tri ? chti_pkg::AW'(lc_r)
                                     : chti_pkg::A_O0 + chti_pkg::AW'(lc_r);
        mem_wdata = head.item.p[lc_r];
        wr_chk    = chti_pkg::CHK_NONE;
        lc_inc    = 1'b1;
        if (load_last) begin
          tri_start  = head.item.is_tri;
          ray_done   = !head.item.is_tri;
          clr_search = !head.item.is_tri;
          pop        = !head.item.is_tri;
        end
      end
      chti_pkg::BK_ACC: begin
        mem_we = uop.last;
        pc_inc = 1'b1;
      end
      chti_pkg::BK_DVS: begin
        if (den_zero) begin
          mem_we    = 1'b1;
          mem_wdata = '0;
          wr_chk    = chti_pkg::CHK_NONE;
          miss_set  = 1'b1;
          pc_inc    = 1'b1;
        end else begin
          dreq.start = 1'b1;
        end
      end
      chti_pkg::BK_DVW: begin
        mem_we    = drsp.done;
        mem_wdata = drsp.quo;
        pc_inc    = drsp.done;
      end
      chti_pkg::BK_DECIDE: begin
        upd_best = is_hit;
        pop      = !head.item.emit;
      end
      chti_pkg::BK_EMIT: begin
        out_load   = out_free;
        clr_search = out_free;
        pop        = out_free;
      end
      default: ;
    endcase
  end

  // scratch memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rda_r    <= mem[uop.a];
    rdb_r    <= mem[uop.b];
    a_one_r  <= (uop.a == chti_pkg::A_ONE);
    b_one_r  <= (uop.b == chti_pkg::A_ONE);
    a_zero_r <= !ray_ok_r && ray_addr(uop.a);
    b_zero_r <= !ray_ok_r && ray_addr(uop.b);
  end

  always_ff @(posedge clk) begin
    if (state_r == chti_pkg::BK_MUL) prod_r <= 64'(opa) * 64'(opb);
    if (state_r == chti_pkg::BK_ACC) acc_r  <= acc_nxt;
    if (mem_we && mem_waddr == chti_pkg::A_T) cand_t_r <= mem_wdata;
    for (int i = 0; i < 3; i++) begin
      if (mem_we && mem_waddr == chti_pkg::A_PT0 + chti_pkg::AW'(i)) cand_pt_r[i] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= chti_pkg::BK_IDLE;
      pc_r     <= '0;
      lc_r     <= '0;
      ray_ok_r <= 1'b0;
      miss_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chti_pkg::BK_IDLE) lc_r <= '0;
      else if (lc_inc)                  lc_r <= lc_r + 1'b1;
      if (tri_start)   pc_r <= '0;
      else if (pc_inc) pc_r <= pc_r + 1'b1;
      if (ray_done) ray_ok_r <= 1'b1;
      if (tri_start) miss_r <= 1'b0;
      else if (miss_set || (mem_we && chti_pkg::chk_miss(wr_chk, mem_wdata))) miss_r <= 1'b1;
    end
  end

  // nearest-hit state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= chti_pkg::MAX_DIST_RST;
      best_idx_r  <= '0;
      best_pt_r   <= '{default: '0};
      any_hit_r   <= 1'b0;
      count_r     <= '0;
    end else if (clr_search) begin
      best_dist_r <= max_distance;
      best_idx_r  <= '0;
      best_pt_r   <= '{default: '0};
      any_hit_r   <= 1'b0;
      count_r     <= '0;
    end else if (state_r == chti_pkg::BK_DECIDE) begin
      count_r <= (count_r == CNT_MAX) ? '0 : count_r + 1'b1;
      if (upd_best) begin
        best_dist_r <= cand_t_r[chti_pkg::DIST_W-1:0];
        best_idx_r  <= count_r;
        best_pt_r   <= cand_pt_r;
        any_hit_r   <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r <= any_hit_r;
      if (any_hit_r) begin
        out_data_r <= {1'b0, best_pt_r[2], best_pt_r[1], best_pt_r[0], best_dist_r,
                       chti_pkg::IDX_W'(best_idx_r)};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

endmodule

[rtl/core/closest_hit_triangle_intersector_core.sv]
// ----------------------------------------------------------------------------
// closest_hit_triangle_intersector_core - nearest-hit ray/triangle tester
// Ray loads start a search; each triangle is intersected in Q16.16 and the
// closest hit is reported on the triangle marked last.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | content
//  in_     | in  | tvalid/tready        | one request: ray load or triangle
//  out_    | out | tvalid/tready        | one closest-hit result per search
//  cfg_    | in  | psel/penable/pready  | max_distance register, offset 0
//
// A ray load is six coordinate writes into scratch memory.
// A triangle takes 9 load writes, 75 multiply-accumulate micro-ops, each
// passing through the read, multiply and accumulate states on the single
// 32x32 multiplier, and three divisions on the bit-serial divider.
// Reset is synchronous; the two-entry request queue keeps taking requests
// while the engine is busy, and a finished result waits in the output
// register without holding up the queue until the next result is due.
// ----------------------------------------------------------------------------
module closest_hit_triangle_intersector_core #(
  parameter int MAX_TRIANGLES = chti_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z (32 b each)
  input  logic [chti_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  logic                             in_tuser,
  // last_item
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit_index (16), hit_distance (31), hit_x, hit_y, hit_z (32), pad (1)
  output logic [chti_pkg::OUT_DATA_W-1:0]  out_tdata,
  // hit
  output logic                             out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  logic [chti_pkg::DIST_W-1:0] max_dist_r;
  logic                        cfg_wr;
  chti_pkg::fe_head_t          head;
  logic                        pop;
  chti_pkg::div_req_t          dreq;
  chti_pkg::div_rsp_t          drsp;

  // register file: only max_distance, decoded from paddr bit 2; offsets with bit 2 set read zero, writes dropped
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == chti_pkg::CFG_IDX_MAX_DIST);
  assign cfg_prdata = (cfg_paddr[2] == chti_pkg::CFG_IDX_MAX_DIST) ? {1'b0, max_dist_r}
                                                                   : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n)      max_dist_r <= chti_pkg::MAX_DIST_RST;
    else if (cfg_wr) max_dist_r <= cfg_pwdata[chti_pkg::DIST_W-1:0];
  end

  // front: intake and queue
  chti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .head      (head),
    .pop       (pop)
  );

  // back: micro-op engine, best-hit state, result register
  chti_back #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .max_distance (max_dist_r),
    .dreq         (dreq),
    .drsp         (drsp),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

  // shared divider for t, v and w
  chti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

endmodule

[sim/closest_hit_triangle_intersector_core_tb.sv]
// ----------------------------------------------------------------------------
// closest_hit_triangle_intersector_core_tb - self-checking bench for the core
// Streams ray loads and triangle requests into the core. A Q16.16 nearest-hit
// predictor runs on every accepted request, and each closest-hit result is
// checked field by field. max_distance is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module closest_hit_triangle_intersector_core_tb;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint UNIT   = 64'sd65536;
  localparam logic   REQ_RAY = 1'b0;
  localparam logic   REQ_TRI = 1'b1;

  typedef struct packed {
    logic                   is_tri;
    logic                   last;
    logic [8:0][31:0]       p;      // p[0] = p0_x ... p[8] = p2_z
  } tri_req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] idx;
    logic [30:0] distance;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } hit_rsp_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [chti_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // p0_x..p2_z, 32 b each
  logic                            in_tuser = 1'b0; // req_type
  logic                            in_tlast = 1'b0; // last_item
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [chti_pkg::OUT_DATA_W-1:0] out_tdata;       // hit_index, hit_distance, hit_x/y/z
  logic                            out_tuser;       // hit
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [2:0]                      cfg_paddr = '0;
  logic [31:0]                     cfg_pwdata = '0;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  closest_hit_triangle_intersector_core dut (.*);

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // nearest-hit predictor state
  // --------------------------------------------------------------------------
  longint   ray_o[3], ray_d[3];
  longint   near_t, near_p[3];
  int       near_idx, tri_count;
  bit       any_hit;
  longint   bound;                // max_distance as written
  longint   va[3], vb[3], vc[3];  // triangle under test
  longint   hit_t, hit_p[3];

  hit_rsp_t expected_hits[$];
  tri_req_t pend_reqs[$];
  int       n_errors = 0;
  int       n_results = 0;

  function automatic longint sat(input longint x);
    return (x > S32_HI) ? S32_HI : (x < S32_LO) ? S32_LO : x;
  endfunction

  // floor(a*b / 2^16)
  function automatic longint fm(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint fdv(input longint n, input longint d);
    return sat((n * UNIT) / d);
  endfunction

  function automatic longint dot(input longint a0, a1, a2, b0, b1, b2);
    return sat(fm(a0, b0) + fm(a1, b1) + fm(a2, b2));
  endfunction

  function automatic void new_search();
    near_t = bound;
    near_idx = 0;
    near_p = '{0, 0, 0};
    any_hit = 0;
    tri_count = 0;
  endfunction

  // plane + barycentric test of va/vb/vc against the stored ray
  function automatic bit tri_hits();
    longint cb[3], ab[3], n[3], v0[3], v1[3], v2[3], pt[3];
    longint ndd, num, t, d00, d01, d11, d20, d21, den, v, w, u;
    for (int i = 0; i < 3; i++) begin
      cb[i] = sat(vc[i] - vb[i]);
      ab[i] = sat(va[i] - vb[i]);
    end
    n[0] = sat(fm(cb[1], ab[2]) - fm(cb[2], ab[1]));
    n[1] = sat(fm(cb[2], ab[0]) - fm(cb[0], ab[2]));
    n[2] = sat(fm(cb[0], ab[1]) - fm(cb[1], ab[0]));
    ndd = dot(n[0], n[1], n[2], ray_d[0], ray_d[1], ray_d[2]);
    if (ndd == 0) return 0;           // ray parallel to plane
    num = 0;
    for (int i = 0; i < 3; i++) num += fm(n[i], va[i]) - fm(n[i], ray_o[i]);
    t = fdv(sat(num), ndd);
    if (t <= 0) return 0;             // behind or at origin
    for (int i = 0; i < 3; i++) pt[i] = sat(ray_o[i] + fm(ray_d[i], t));
    for (int i = 0; i < 3; i++) begin
      v0[i] = sat(vb[i] - va[i]);
      v1[i] = sat(vc[i] - va[i]);
      v2[i] = sat(pt[i] - va[i]);
    end
    d00 = dot(v0[0], v0[1], v0[2], v0[0], v0[1], v0[2]);
    d01 = dot(v0[0], v0[1], v0[2], v1[0], v1[1], v1[2]);
    d11 = dot(v1[0], v1[1], v1[2], v1[0], v1[1], v1[2]);
    d20 = dot(v2[0], v2[1], v2[2], v0[0], v0[1], v0[2]);
    d21 = dot(v2[0], v2[1], v2[2], v1[0], v1[1], v1[2]);
    den = sat(fm(d00, d11) - fm(d01, d01));
    if (den == 0) return 0;           // degenerate triangle
    v = fdv(sat(fm(d20, d11) - fm(d21, d01)), den);
    if (v < 0 || v > UNIT) return 0;
    w = fdv(sat(fm(d00, d21) - fm(d01, d20)), den);
    if (w < 0 || w > UNIT) return 0;
    u = sat(UNIT - w - v);
    if (u < 0 || u > UNIT) return 0;
    if (t >= near_t) return 0;
    hit_t = t;
    hit_p = pt;
    return 1;
  endfunction

  function automatic void predict(input tri_req_t r);
    hit_rsp_t e;
    for (int i = 0; i < 3; i++) begin
      va[i] = longint'($signed(r.p[i]));
      vb[i] = longint'($signed(r.p[3 + i]));
      vc[i] = longint'($signed(r.p[6 + i]));
    end
    if (r.is_tri == REQ_RAY) begin
      ray_o = va;
      ray_d = vb;
      new_search();
      return;
    end
    if (tri_hits()) begin
      near_t = hit_t;
      near_idx = tri_count;
      near_p = hit_p;
      any_hit = 1;
    end
    tri_count = (tri_count + 1) % chti_pkg::MAX_TRIANGLES_DEF;
    if (!r.last) return;
    e = '0;
    if (any_hit) begin
      e.hit = 1'b1;
      e.idx = near_idx[15:0];
      e.distance = near_t[30:0];
      e.x = near_p[0][31:0];
      e.y = near_p[1][31:0];
      e.z = near_p[2][31:0];
    end
    expected_hits.push_back(e);
    new_search();
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: result %0d %s got %h want %h", $time, n_results, what, got, want);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // sampling at the rising edge: input acceptance feeds the predictor,
  // output acceptance is checked against the oldest expectation
  // --------------------------------------------------------------------------
  tri_req_t cur;
  bit       taken = 0;

  always @(posedge clk) begin
    hit_rsp_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (expected_hits.size() == 0) begin
          report("unexpected", out_tdata[31:0], 32'h0);
        end else begin
          e = expected_hits.pop_front();
          if (out_tuser !== e.hit) report("hit", out_tuser, e.hit);
          if (out_tdata[15:0] !== e.idx) report("hit_index", out_tdata[15:0], e.idx);
          if (out_tdata[46:16] !== e.distance)
            report("hit_distance", out_tdata[46:16], e.distance);
          if (out_tdata[78:47] !== e.x) report("hit_x", out_tdata[78:47], e.x);
          if (out_tdata[110:79] !== e.y) report("hit_y", out_tdata[110:79], e.y);
          if (out_tdata[142:111] !== e.z) report("hit_z", out_tdata[142:111], e.z);
        end
      end
      if (in_tvalid && in_tready) begin
        predict(cur);
        taken = 1;
      end
    end
  end

  // sender: bursts of random length, random gaps; changes at the falling edge
  int burst_left = 0, gap_left = 0;

  always @(negedge clk) begin
    logic v;
    v = in_tvalid;
    if (rst_n && !(in_tvalid && !taken)) begin
      taken = 0;
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_reqs.size() > 0) begin
        cur = pend_reqs.pop_front();
        v = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_tvalid <= v;
    in_tdata <= cur.p;
    in_tuser <= cur.is_tri;
    in_tlast <= cur.last;
  end

  // receiver: stall pattern switches at random intervals; one long hold-off
  int  hold_cycles = 0, mode_left = 0, rx_mode = 0;
  bit  held = 0;

  always @(negedge clk) begin
    logic r;
    if (hold_cycles > 0) begin
      hold_cycles--;
      r = 1'b0;
    end else if (!held && n_results >= 30) begin
      held = 1;
      hold_cycles = 4000;   // long enough for several results to back up
      r = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(100, 600);
        rx_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (rx_mode)
        0:       r = 1'b1;
        1:       r = ($urandom_range(0, 3) != 0);
        default: r = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_tready <= r;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic logic [31:0] fx(input int units);
    return 32'(units * 65536);
  endfunction

  function automatic void push(input logic kind, input logic last,
                               input logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8);
    tri_req_t r;
    r.is_tri = kind;
    r.last = last;
    r.p = {c8, c7, c6, c5, c4, c3, c2, c1, c0};
    pend_reqs.push_back(r);
  endfunction

  function automatic void push_noise();
    push($urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // ray load, then a run of triangles mostly placed across the ray
  function automatic void push_search(input int n_tri);
    int ox, oy, oz, dx, dy, dz, s, r, qx, qy, qz, k;
    ox = ($urandom_range(0, 40) - 20) * 65536;
    oy = ($urandom_range(0, 40) - 20) * 65536;
    oz = ($urandom_range(0, 40) - 20) * 65536;
    dx = $urandom_range(0, 65536) - 32768;
    dy = $urandom_range(0, 65536) - 32768;
    dz = $urandom_range(65536, 131072) * ($urandom_range(0, 1) ? 1 : -1);
    push(REQ_RAY, $urandom_range(0, 1), ox, oy, oz, dx, dy, dz,
         $urandom, $urandom, $urandom);
    for (int i = 0; i < n_tri; i++) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        s = $urandom_range(1, 20);
        qx = ox + dx * s;
        qy = oy + dy * s;
        qz = oz + dz * s;
        r = (k == 6) ? $urandom_range(1, 65536) : $urandom_range(65536, 8 * 65536);
        if ($urandom_range(0, 4) == 0) qx += $urandom_range(0, 16) * 65536;
        push(REQ_TRI, i == n_tri - 1,
             qx - r, qy - r, qz + $urandom_range(0, 32768) - 16384,
             qx + r, qy - r, qz + $urandom_range(0, 32768) - 16384,
             qx, qy + r, qz + $urandom_range(0, 32768) - 16384);
      end else if (k < 9) begin
        push(REQ_TRI, i == n_tri - 1,
             fx($urandom_range(0, 60) - 30), fx($urandom_range(0, 60) - 30),
             fx($urandom_range(0, 60) - 30), fx($urandom_range(0, 60) - 30),
             fx($urandom_range(0, 60) - 30), fx($urandom_range(0, 60) - 30),
             fx($urandom_range(0, 60) - 30), fx($urandom_range(0, 60) - 30),
             fx($urandom_range(0, 60) - 30));
      end else begin
        push(REQ_TRI, i == n_tri - 1, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endfunction

  task automatic drain();
    while (pend_reqs.size() != 0 || in_tvalid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (800) @(posedge clk);  // a triangle without result may still be running
  endtask

  task automatic write_bound(input logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {chti_pkg::CFG_IDX_MAX_DIST, 2'b00};
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    bound = longint'(v[30:0]);
  endtask

  initial begin
    logic [31:0] bounds[4];
    bound = longint'(chti_pkg::MAX_DIST_RST);
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, 0};
    new_search();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: triangle before any ray load sees the zero ray
    push(REQ_TRI, 1, fx(-1), fx(-1), fx(5), fx(1), fx(-1), fx(5), 0, fx(1), fx(5));
    // ray load with the last mark: the mark is ignored
    push(REQ_RAY, 1, 0, 0, 0, 0, 0, fx(1), $urandom, $urandom, $urandom);
    push(REQ_TRI, 0, fx(-1), fx(-1), fx(5), fx(1), fx(-1), fx(5), 0, fx(1), fx(5));
    push(REQ_TRI, 0, fx(-1), fx(-1), fx(3), fx(1), fx(-1), fx(3), 0, fx(1), fx(3));
    push(REQ_TRI, 0, fx(-1), fx(-1), fx(8), fx(1), fx(-1), fx(8), 0, fx(1), fx(8));
    // plane holds the ray direction: parallel
    push(REQ_TRI, 0, fx(2), 0, 0, fx(2), fx(1), 0, fx(2), 0, fx(1));
    // behind the origin
    push(REQ_TRI, 0, fx(-1), fx(-1), fx(-4), fx(1), fx(-1), fx(-4), 0, fx(1), fx(-4));
    // collinear and one-lsb triangles
    push(REQ_TRI, 0, 0, 0, fx(2), fx(1), fx(1), fx(2), fx(2), fx(2), fx(2));
    push(REQ_TRI, 0, 0, 0, fx(2), 1, 0, fx(2), 0, 1, fx(2));
    // triangle edge through the ray, then a clear miss closing the search
    push(REQ_TRI, 0, 0, fx(-1), fx(4), fx(2), fx(-1), fx(4), 0, fx(1), fx(4));
    push(REQ_TRI, 1, fx(9), fx(9), fx(2), fx(11), fx(9), fx(2), fx(10), fx(11), fx(2));
    // field extremes
    push(REQ_RAY, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    push(REQ_TRI, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push(REQ_TRI, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
         32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    push(REQ_RAY, 0, 32'hFFFF_FFFF, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000,
         32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(REQ_TRI, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
    drain();

    // random phases, each under its own distance bound
    bounds[0] = 32'h0000_0000;
    bounds[1] = 32'h0008_0000;
    bounds[2] = $urandom;
    bounds[3] = 32'h7FFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      write_bound(bounds[ph]);
      while (pend_reqs.size() < 105) begin
        if ($urandom_range(0, 9) < 8) push_search($urandom_range(1, 5));
        else repeat ($urandom_range(1, 3)) push_noise();
      end
      push(REQ_TRI, 1, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom);
      drain();
    end

    if (n_errors == 0) begin
      $display("closest_hit_triangle_intersector_core: match");
    end else begin
      $display("closest_hit_triangle_intersector_core: mismatch");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2000000;
    $display("closest_hit_triangle_intersector_core: mismatch");
    $finish;
  end

endmodule
